// ----- hw/rtl/rtp_pkg.sv -----
// Shared types, codes and constants of the request TLV parser.
package rtp_pkg;

  // Number of request types that the parser accepts.
  localparam int unsigned NumTypes = 4;
  // Number of expected-count registers, one for each encodable type.
  localparam int unsigned NumCfgRegs = 4;
  // Largest number of arguments in one request.
  localparam logic [1:0] MaxArgs = 2'd3;

  typedef logic [1:0] arg_cnt_t;
  typedef arg_cnt_t [NumCfgRegs-1:0] exp_args_t;

  // Reset values of the expected argument counts, indexed by type.
  localparam exp_args_t ExpArgsReset = '{2'd0, 2'd2, 2'd1, 2'd3};

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgExpType0 = 2'd0,
    CfgExpType1 = 2'd1,
    CfgExpType2 = 2'd2,
    CfgExpType3 = 2'd3
  } cfg_idx_e;

  // Parser phase.
  typedef enum logic [2:0] {
    PhType = 3'd0,
    PhLen  = 3'd1,
    PhArg  = 3'd2,
    PhDone = 3'd3,
    PhErr  = 3'd4
  } phase_e;

  // Event reported with every word.
  typedef enum logic [2:0] {
    EvType    = 3'd0,
    EvLen     = 3'd1,
    EvByte    = 3'd2,
    EvDone    = 3'd3,
    EvIgnored = 3'd4,
    EvError   = 3'd5
  } event_e;

  // Sticky error cause.
  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseBadType = 2'd1,
    CauseCount   = 2'd2,
    CauseTooMany = 2'd3
  } cause_e;

  // Parser state carried from one word to the next.
  typedef struct packed {
    phase_e     phase;
    logic [1:0] latched_type;
    arg_cnt_t   args_seen;
    logic [7:0] arg_length;
    logic [7:0] arg_bytes_seen;
    cause_e     err_cause;
  } state_t;

  // One result word.
  typedef struct packed {
    event_e     event_res;
    logic [7:0] byte_value;
    logic [1:0] arg_index;
    logic [7:0] byte_index;
    logic       arg_last;
    logic [1:0] request_type;
    cause_e     error_cause;
  } result_t;

endpackage

// ----- hw/rtl/rtp_step.sv -----
// One parse step: next parser state and the result word for one received byte.
module rtp_step (
  input  rtp_pkg::state_t    state_i,
  input  logic [7:0]         rx_byte_i,
  input  rtp_pkg::exp_args_t exp_args_i,
  output rtp_pkg::state_t    state_o,
  output rtp_pkg::result_t   result_o
);

  logic       type_ok;
  logic       count_ok;
  logic       too_many;
  logic [7:0] bytes_next;

  // Shared decode of the received byte against the current state.
  assign type_ok    = (32'(rx_byte_i) < rtp_pkg::NumTypes) &&
                      (32'(rx_byte_i) < rtp_pkg::NumCfgRegs);
  assign count_ok   = (state_i.args_seen == exp_args_i[state_i.latched_type]);
  assign too_many   = (state_i.args_seen >= rtp_pkg::MaxArgs);
  assign bytes_next = state_i.arg_bytes_seen + 8'd1;

  // Next state.
  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      rtp_pkg::PhType: begin
        if (!type_ok) begin
          state_o.phase     = rtp_pkg::PhErr;
          state_o.err_cause = rtp_pkg::CauseBadType;
        end else begin
          state_o.phase        = rtp_pkg::PhLen;
          state_o.latched_type = rx_byte_i[1:0];
          state_o.args_seen    = '0;
        end
      end
      rtp_pkg::PhLen: begin
        priority if (rx_byte_i == 8'd0) begin
          if (count_ok) begin
            state_o.phase = rtp_pkg::PhDone;
          end else begin
            state_o.phase     = rtp_pkg::PhErr;
            state_o.err_cause = rtp_pkg::CauseCount;
          end
        end else if (too_many) begin
          state_o.phase     = rtp_pkg::PhErr;
          state_o.err_cause = rtp_pkg::CauseTooMany;
        end else begin
          state_o.phase          = rtp_pkg::PhArg;
          state_o.args_seen      = state_i.args_seen + 2'd1;
          state_o.arg_length     = rx_byte_i;
          state_o.arg_bytes_seen = '0;
        end
      end
      rtp_pkg::PhArg: begin
        state_o.arg_bytes_seen = bytes_next;
        if (bytes_next >= state_i.arg_length) begin
          state_o.phase = rtp_pkg::PhLen;
        end
      end
      rtp_pkg::PhDone: begin
        state_o.phase = rtp_pkg::PhDone;
      end
      default: begin
        state_o.phase = rtp_pkg::PhErr;
      end
    endcase
  end

  // Result word; type and cause are reported as they stand after this byte.
  always_comb begin
    result_o              = '0;
    result_o.byte_value   = rx_byte_i;
    result_o.request_type = state_o.latched_type;
    result_o.error_cause  = state_o.err_cause;
    unique case (state_i.phase)
      rtp_pkg::PhType: begin
        result_o.event_res = type_ok ? rtp_pkg::EvType : rtp_pkg::EvError;
      end
      rtp_pkg::PhLen: begin
        priority if (rx_byte_i == 8'd0) begin
          result_o.event_res = count_ok ? rtp_pkg::EvDone : rtp_pkg::EvError;
        end else if (too_many) begin
          result_o.event_res = rtp_pkg::EvError;
        end else begin
          result_o.event_res = rtp_pkg::EvLen;
          result_o.arg_index = state_o.args_seen;
        end
      end
      rtp_pkg::PhArg: begin
        result_o.event_res  = rtp_pkg::EvByte;
        result_o.arg_index  = state_i.args_seen;
        result_o.byte_index = state_i.arg_bytes_seen;
        result_o.arg_last   = (bytes_next >= state_i.arg_length);
      end
      rtp_pkg::PhDone: begin
        result_o.event_res = rtp_pkg::EvIgnored;
      end
      default: begin
        result_o.event_res = rtp_pkg::EvError;
      end
    endcase
  end

endmodule

// ----- hw/rtl/request_tlv_parser.sv -----
// Top level of the request TLV parser: config registers, parser state and result register.
// The parser takes one request byte per cycle, unless the input is stalled, and gives one
// result word per byte, registered, in the cycle after the byte is accepted; a byte can be
// accepted in every cycle that the output is not stalled, since the only loop is the update
// of the parser state register. The result register holds a word while the output is stalled,
// and the input is stalled only while that word is held. Completion and errors are sticky until
// reset. Configuration writes are always taken; an index beyond the four expected-count registers is ignored.
module request_tlv_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // Result words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] byte_value_o,
  output logic [1:0] arg_index_o,
  output logic [7:0] byte_index_o,
  output logic       arg_last_o,
  output logic [1:0] request_type_o,
  output logic [1:0] error_cause_o
);

  rtp_pkg::exp_args_t exp_args_q;
  rtp_pkg::state_t    state_q, state_d;
  rtp_pkg::result_t   result_q, result_d;
  logic               out_valid_q;
  logic               in_accept;

  // Handshake: the result register frees when its word is taken.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Expected argument count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_args_q <= rtp_pkg::ExpArgsReset;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (32'(cfg_index_i) < rtp_pkg::NumCfgRegs)) begin
      exp_args_q[cfg_index_i[1:0]] <= cfg_data_i[1:0];
    end
  end

  // Parse step for the byte at the input.
  rtp_step u_step (
    .state_i    (state_q),
    .rx_byte_i  (rx_byte_i),
    .exp_args_i (exp_args_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: rtp_pkg::PhType, err_cause: rtp_pkg::CauseNone, default: '0};
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = result_q.event_res;
  assign byte_value_o   = result_q.byte_value;
  assign arg_index_o    = result_q.arg_index;
  assign byte_index_o   = result_q.byte_index;
  assign arg_last_o     = result_q.arg_last;
  assign request_type_o = result_q.request_type;
  assign error_cause_o  = result_q.error_cause;

`ifndef SYNTH
  // An error word always carries a nonzero cause.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == rtp_pkg::EvError) |-> error_cause_o != rtp_pkg::CauseNone)
    else $error("error word without a cause");

  // The last-byte flag only marks argument bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && arg_last_o) |-> event_res_o == rtp_pkg::EvByte)
    else $error("last flag on a word that is not an argument byte");

  // The error phase is left only by reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == rtp_pkg::PhErr) |=> (state_q.phase == rtp_pkg::PhErr))
    else $error("parser left the error phase");

  // Completion is sticky.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == rtp_pkg::PhDone) |=> (state_q.phase == rtp_pkg::PhDone))
    else $error("parser left the done phase");
`endif

endmodule

// ----- test/request_tlv_parser_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the request TLV parser: directed request head, random tail.
module request_tlv_parser_test;

  localparam int unsigned TotalItems  = 1250;
  localparam int unsigned IdleChunk   = 100;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned MaxReported = 10;

  // How the single request of this run is brought to an end.
  typedef enum int {EndBadType, EndComplete, EndCountMismatch, EndTooMany} request_end_e;

  // One row of the directed request head: the byte and its known result word.
  typedef struct {
    logic [7:0]       rx;
    rtp_pkg::result_t word;
  } head_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] event_res_o;
  logic [7:0] byte_value_o;
  logic [1:0] arg_index_o;
  logic [7:0] byte_index_o;
  logic       arg_last_o;
  logic [1:0] request_type_o;
  logic [1:0] error_cause_o;

  // Parser state as the predictor sees it.
  rtp_pkg::phase_e    ps_phase;
  logic [1:0]         ps_type;
  rtp_pkg::arg_cnt_t  ps_args;
  logic [7:0]         ps_len;
  logic [7:0]         ps_seen;
  rtp_pkg::cause_e    ps_cause;
  rtp_pkg::exp_args_t exp_counts;

  rtp_pkg::result_t expected_events[$];
  head_row_t        request_head[6];
  int unsigned      items_sent = 0;
  int unsigned      results_checked = 0;
  int unsigned      cfg_writes = 0;
  int unsigned      errors = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      idle_mode = 0;
  bit               hold_req = 1'b0;

  request_tlv_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .byte_value_o   (byte_value_o),
    .arg_index_o    (arg_index_o),
    .byte_index_o   (byte_index_o),
    .arg_last_o     (arg_last_o),
    .request_type_o (request_type_o),
    .error_cause_o  (error_cause_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result word of one accepted byte and advances the parser state.
  function automatic rtp_pkg::result_t parse_rx_byte(input logic [7:0] b);
    rtp_pkg::result_t r;
    r = '0;
    r.byte_value = b;
    case (ps_phase)
      rtp_pkg::PhType: begin
        if (b >= rtp_pkg::NumTypes) begin
          ps_cause    = rtp_pkg::CauseBadType;
          ps_phase    = rtp_pkg::PhErr;
          r.event_res = rtp_pkg::EvError;
        end else begin
          ps_type     = b[1:0];
          ps_args     = '0;
          ps_phase    = rtp_pkg::PhLen;
          r.event_res = rtp_pkg::EvType;
        end
      end
      rtp_pkg::PhLen: begin
        if (b == 8'd0) begin
          if (ps_args == exp_counts[ps_type]) begin
            ps_phase    = rtp_pkg::PhDone;
            r.event_res = rtp_pkg::EvDone;
          end else begin
            ps_cause    = rtp_pkg::CauseCount;
            ps_phase    = rtp_pkg::PhErr;
            r.event_res = rtp_pkg::EvError;
          end
        end else if (ps_args >= rtp_pkg::MaxArgs) begin
          ps_cause    = rtp_pkg::CauseTooMany;
          ps_phase    = rtp_pkg::PhErr;
          r.event_res = rtp_pkg::EvError;
        end else begin
          ps_args     = ps_args + 2'd1;
          ps_len      = b;
          ps_seen     = 8'd0;
          ps_phase    = rtp_pkg::PhArg;
          r.arg_index = ps_args;
          r.event_res = rtp_pkg::EvLen;
        end
      end
      rtp_pkg::PhArg: begin
        r.arg_index  = ps_args;
        r.byte_index = ps_seen;
        ps_seen      = ps_seen + 8'd1;
        if (ps_seen >= ps_len) begin
          r.arg_last = 1'b1;
          ps_phase   = rtp_pkg::PhLen;
        end
        r.event_res = rtp_pkg::EvByte;
      end
      rtp_pkg::PhDone: r.event_res = rtp_pkg::EvIgnored;
      default: begin
        ps_phase    = rtp_pkg::PhErr;
        r.event_res = rtp_pkg::EvError;
      end
    endcase
    r.request_type = ps_type;
    r.error_cause  = ps_cause;
    return r;
  endfunction

  // Register data with random upper bits, which the block drops.
  function automatic logic [7:0] cfg_word(input rtp_pkg::arg_cnt_t count);
    return {6'($urandom_range(63)), count};
  endfunction

  // Offers one byte after a random gap and records its expected result word.
  task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
                         input rtp_pkg::result_t typed_word = '0);
    int unsigned      idle_pct;
    rtp_pkg::result_t predicted;
    idle_mode = (items_sent / IdleChunk) % 4;
    idle_pct  = (idle_mode == 1) ? 51 : (idle_mode == 3) ? 19 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    predicted = parse_rx_byte(b);
    expected_events.push_back(typed ? typed_word : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering bytes and waits until every expected word has arrived.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
  endtask

  // Writes one configuration register and mirrors it in the predictor.
  task automatic write_cfg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < rtp_pkg::NumCfgRegs) exp_counts[idx[1:0]] = data[1:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: random stalls by phase, and one long hold-off on request.
  initial begin
    int unsigned stall_pct;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall_pct   = (idle_mode == 2) ? 51 : (idle_mode == 3) ? 19 : 0;
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    rtp_pkg::result_t seen;
    rtp_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {event_res_o, byte_value_o, arg_index_o, byte_index_o, arg_last_o,
              request_type_o, error_cause_o};
      results_checked++;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("Unexpected word: event %0d byte %02h", seen.event_res, seen.byte_value);
      end else begin
        want = expected_events.pop_front();
        if (seen.event_res !== want.event_res || seen.byte_value !== want.byte_value ||
            seen.arg_index !== want.arg_index || seen.byte_index !== want.byte_index ||
            seen.arg_last !== want.arg_last || seen.request_type !== want.request_type ||
            seen.error_cause !== want.error_cause) begin
          errors++;
          if (errors <= MaxReported) begin
            $display("Mismatch at word %0d:", results_checked);
            $display("  expected ev %0d byte %02h arg %0d idx %0d last %0d type %0d cause %0d",
                     want.event_res, want.byte_value, want.arg_index, want.byte_index,
                     want.arg_last, want.request_type, want.error_cause);
            $display("  actual   ev %0d byte %02h arg %0d idx %0d last %0d type %0d cause %0d",
                     seen.event_res, seen.byte_value, seen.arg_index, seen.byte_index,
                     seen.arg_last, seen.request_type, seen.error_cause);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: one request, several register settings, then bytes after its end.
  initial begin
    request_end_e request_end;
    int unsigned  arg3_len;
    int unsigned  pick;
    logic [7:0]   b;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'd0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 8'd0;
    cfg_data_i  = 8'd0;
    rst_ni      = 1'b0;
    ps_phase    = rtp_pkg::PhType;
    ps_type     = '0;
    ps_args     = '0;
    ps_len      = 8'd0;
    ps_seen     = 8'd0;
    ps_cause    = rtp_pkg::CauseNone;
    exp_counts  = rtp_pkg::ExpArgsReset;
    request_head = '{
      '{8'd3,  '{rtp_pkg::EvType, 8'd3,  2'd0, 8'd0, 1'b0, 2'd3, rtp_pkg::CauseNone}},
      '{8'd1,  '{rtp_pkg::EvLen,  8'd1,  2'd1, 8'd0, 1'b0, 2'd3, rtp_pkg::CauseNone}},
      '{8'd0,  '{rtp_pkg::EvByte, 8'd0,  2'd1, 8'd0, 1'b1, 2'd3, rtp_pkg::CauseNone}},
      '{8'd2,  '{rtp_pkg::EvLen,  8'd2,  2'd2, 8'd0, 1'b0, 2'd3, rtp_pkg::CauseNone}},
      '{8'hFF, '{rtp_pkg::EvByte, 8'hFF, 2'd2, 8'd0, 1'b0, 2'd3, rtp_pkg::CauseNone}},
      '{8'h80, '{rtp_pkg::EvByte, 8'h80, 2'd2, 8'd1, 1'b1, 2'd3, rtp_pkg::CauseNone}}
    };
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Only one request fits in a run, since completion and errors stay until reset.
    pick = $urandom_range(7);
    request_end = (pick == 0) ? EndBadType :
                  (pick < 4)  ? EndComplete :
                  (pick < 6)  ? EndCountMismatch : EndTooMany;

    // First setting: the count extremes, plus a write to an index beyond the registers.
    write_cfg(8'(rtp_pkg::CfgExpType0), cfg_word(2'd0));
    write_cfg(8'(rtp_pkg::CfgExpType1), cfg_word(2'd3));
    write_cfg(8'(rtp_pkg::CfgExpType2), cfg_word(2'($urandom_range(3))));
    write_cfg(8'(rtp_pkg::CfgExpType3), cfg_word(2'd0));
    write_cfg(8'($urandom_range(255, rtp_pkg::NumCfgRegs)), 8'($urandom()));

    // A type byte out of range poisons the whole request.
    if (request_end == EndBadType) begin
      b = 8'($urandom_range(255, rtp_pkg::NumTypes));
      send_rx(b, 1'b1,
              '{rtp_pkg::EvError, b, 2'd0, 8'd0, 1'b0, 2'd0, rtp_pkg::CauseBadType});
    end

    // Directed head: type 3, a one-byte name, a two-byte password.
    foreach (request_head[i])
      send_rx(request_head[i].rx, request_end != EndBadType, request_head[i].word);

    // Second setting, taken mid-request while the block is idle.
    drain_results();
    for (int i = 0; i < rtp_pkg::NumCfgRegs; i++) write_cfg(8'(i), 8'($urandom()));

    // Third argument: often the longest length, so the byte index reaches 254, its largest value.
    arg3_len = $urandom_range(1) ? 255 : $urandom_range(254, 1);
    send_rx(8'(arg3_len));
    repeat (arg3_len) send_rx(8'($urandom()));

    // Third setting decides how the terminator is judged for type 3.
    drain_results();
    write_cfg(8'(rtp_pkg::CfgExpType0), cfg_word(2'($urandom_range(3))));
    write_cfg(8'(rtp_pkg::CfgExpType1), cfg_word(2'($urandom_range(3))));
    write_cfg(8'(rtp_pkg::CfgExpType2), cfg_word(2'($urandom_range(3))));
    if (request_end == EndComplete)
      write_cfg(8'(rtp_pkg::CfgExpType3), cfg_word(rtp_pkg::MaxArgs));
    else if (request_end == EndCountMismatch)
      write_cfg(8'(rtp_pkg::CfgExpType3), cfg_word(2'($urandom_range(2))));
    else
      write_cfg(8'(rtp_pkg::CfgExpType3), cfg_word(2'($urandom_range(3))));

    // Terminator, or a fourth argument length.
    if (request_end == EndTooMany) send_rx(8'($urandom_range(255, 1)));
    else send_rx(8'd0);

    // Bytes after the end, with one long receiver hold-off while bytes keep coming.
    hold_req = 1'b1;
    while (items_sent < TotalItems) begin
      b = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom());
      send_rx(b);
    end

    drain_results();
    repeat (10) @(negedge clk_i);
    errors += expected_events.size();
    $display("Sent %0d bytes, checked %0d words, made %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Request ended by %s; third argument was %0d bytes long.",
             request_end.name(), arg3_len);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- request_tlv_parser.f -----
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_step.sv
hw/rtl/request_tlv_parser.sv
test/request_tlv_parser_test.sv
